// ----- sv/pcsp_pkg.sv -----
// Shared types and constants for the PC-indexed stride prefetcher.
// No dependencies; imported by every module of the block.
package pcsp_pkg;

    localparam int unsigned TABLE_ENTRIES_DEFAULT = 256;
    localparam int unsigned QUEUE_DEPTH           = 4;
    localparam int unsigned QUEUE_PTR_W           = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] LINE_LOG2_RESET = 4'd6;
    localparam logic [1:0] CONF_MAX        = 2'd3;
    localparam logic [1:0] CONF_ISSUE      = 2'd1;

    // One classified access on its way from the front to the back.
    typedef struct packed {
        logic [63:0] pc;
        logic [63:0] line;
        logic        missed;
    } access_t;

    // One table entry as it sits in the table memory.
    typedef struct packed {
        logic        valid;
        logic [63:0] tag_pc;
        logic [63:0] prev_line;
        logic [63:0] stride;
        logic [1:0]  confidence;
    } entry_t;

    // Status that the back reports to the front.
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// ----- sv/pcsp_front.sv -----
// Front of the prefetcher: takes accesses, drops prefetch accesses and
// reduces the byte address to a line number. Depends on pcsp_pkg.
module pcsp_front (
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [127:0]          s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,
    input  logic [3:0]            line_size_log2,
    input  pcsp_pkg::back_status_t back_status,
    input  logic                  queue_full,
    output logic                  push,
    output pcsp_pkg::access_t     push_data
);
    import pcsp_pkg::*;

    logic [63:0] access_pc;
    logic [63:0] access_addr;
    logic        missed;
    logic        is_prefetch;

    assign access_pc   = s_axis_tdata[63:0];
    assign access_addr = s_axis_tdata[127:64];
    assign missed      = s_axis_tuser[0];
    assign is_prefetch = s_axis_tuser[1];

    // Nothing is taken while the table is being cleared after reset.
    assign s_axis_tready = !queue_full && !back_status.clearing;

    // Prefetch accesses complete their transfer but never reach the table.
    assign push = s_axis_tvalid && s_axis_tready && !is_prefetch;

    assign push_data.pc     = access_pc;
    assign push_data.line   = access_addr >> line_size_log2;
    assign push_data.missed = missed;

endmodule

// ----- sv/pcsp_queue.sv -----
// Short queue that decouples the front from the table back end.
// Depends on pcsp_pkg for the item type and depth.
module pcsp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pcsp_pkg::access_t push_data,
    output logic              full,
    input  logic              pop,
    output pcsp_pkg::access_t pop_data,
    output logic              empty
);
    import pcsp_pkg::*;

    access_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/pcsp_back.sv -----
// Back end of the prefetcher: table memory, stride training and the
// prefetch output register. Depends on pcsp_pkg.
module pcsp_back #(
    parameter int unsigned TABLE_ENTRIES = pcsp_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [3:0]             line_size_log2,
    input  logic                   queue_empty,
    input  pcsp_pkg::access_t      queue_data,
    output logic                   pop,
    output pcsp_pkg::back_status_t status,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [63:0]            m_axis_tdata
);
    import pcsp_pkg::*;

    // Indexed by low pc bits: user keeps TABLE_ENTRIES a power of two; unchecked.
    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    access_t          cur_reg;
    logic             out_valid_reg;
    logic [63:0]      out_data_reg;

    entry_t           table_mem [TABLE_ENTRIES];
    entry_t           rd_entry_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    entry_t           trained;

    logic             hit;
    logic [63:0]      stride;
    logic             same_stride;
    logic [1:0]       conf_next;
    logic             emit;
    logic [63:0]      pf_addr;
    logic             proceed;

    always_comb begin
        hit         = rd_entry_reg.valid && (rd_entry_reg.tag_pc == cur_reg.pc);
        stride      = cur_reg.line - rd_entry_reg.prev_line;
        same_stride = (stride == rd_entry_reg.stride) && (stride != '0);
        if (same_stride) begin
            conf_next = (rd_entry_reg.confidence < CONF_MAX) ?
                        rd_entry_reg.confidence + 2'd1 : rd_entry_reg.confidence;
        end else begin
            conf_next = '0;
        end

        trained.valid     = 1'b1;
        trained.tag_pc    = cur_reg.pc;
        trained.prev_line = cur_reg.line;
        if (hit) begin
            trained.stride     = stride;
            trained.confidence = conf_next;
        end else begin
            trained.stride     = '0;
            trained.confidence = '0;
        end

        // Confidence above zero implies the stride just repeated.
        emit    = hit && (conf_next >= CONF_ISSUE) && cur_reg.missed;
        pf_addr = (cur_reg.line + stride) << line_size_log2;
        proceed = !emit || !out_valid_reg || m_axis_tready;
    end

    assign pop = (state_reg == ST_IDLE) && !queue_empty;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg.pc[IDX_W-1:0];
        mem_wdata = trained;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            ST_LOOK: begin
                mem_we = proceed;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (pop) begin
            rd_entry_reg <= table_mem[queue_data.pc[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (pop) begin
                        cur_reg   <= queue_data;
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (proceed) begin
                        if (emit) begin
                            out_valid_reg <= 1'b1;
                            out_data_reg  <= pf_addr;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign status.clearing = (state_reg == ST_CLEAR);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;

    a_no_pop_while_clearing : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !pop)
        else $error("queue popped during the table clearing pass");

    a_result_from_lookup : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LOOK))
        else $error("prefetch result appeared without a table lookup");

    a_no_overwrite_pending : assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_axis_tready && (state_reg == ST_LOOK) && emit)
        |=> (state_reg == ST_LOOK) && $stable(out_data_reg))
        else $error("pending prefetch result was overwritten");

    a_lookup_follows_pop : assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (state_reg == ST_LOOK))
        else $error("popped access did not enter the lookup step");

endmodule

// ----- sv/pc_stride_prefetcher_top.sv -----
// Top level of the PC-indexed stride prefetcher: configuration register and
// the front, queue and back instances. Depends on pcsp_pkg and all pcsp modules.
//
// Usage: each access arrives as one transfer on the s_axis channel (pc and
// byte address in tdata, miss and prefetch flags in tuser). Accesses that are
// themselves prefetches are taken and dropped. A trained access that missed
// gives one line-aligned prefetch address on the m_axis channel; all others
// give nothing.
// A result passes through the queue, the registered table read and the output register.
// The back end starts the next access only after the read-modify-write of the
// single-port table memory (registered read, then write-back) of the last one.
// Reset: line_size_log2 returns to 6 and the table is swept to invalid entry by
// entry; s_axis_tready stays low during that pass.
// A stalled m_axis receiver holds the result; the queue keeps taking up to
// four accesses meanwhile, then s_axis_tready drops.
// cfg_wdata is written at any edge with cfg_wen high; write it only while idle.
module pc_stride_prefetcher_top #(
    parameter int unsigned TABLE_ENTRIES = pcsp_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wen,
    input  logic [3:0]   cfg_wdata,      // line_size_log2
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // access_pc [63:0], access_addr [127:64]
    input  logic [1:0]   s_axis_tuser,   // missed [0], is_prefetch [1]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata    // prefetch_addr [63:0]
);
    import pcsp_pkg::*;

    logic [3:0]   line_size_log2_reg;
    logic         push;
    access_t      push_data;
    logic         queue_full;
    logic         queue_empty;
    logic         pop;
    access_t      pop_data;
    back_status_t back_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_size_log2_reg <= LINE_LOG2_RESET;
        end else if (cfg_wen) begin
            line_size_log2_reg <= cfg_wdata;
        end
    end

    pcsp_front u_front (
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .line_size_log2 (line_size_log2_reg),
        .back_status    (back_status),
        .queue_full     (queue_full),
        .push           (push),
        .push_data      (push_data)
    );

    pcsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    pcsp_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .line_size_log2 (line_size_log2_reg),
        .queue_empty    (queue_empty),
        .queue_data     (pop_data),
        .pop            (pop),
        .status         (back_status),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

endmodule

// ----- sim/pc_stride_prefetcher_top_test.sv -----
// Self-checking testbench for pc_stride_prefetcher_top: streams accesses into the
// block, predicts each prefetch address with its own stride table, and compares results.
// Depends on pcsp_pkg and the prefetcher RTL.
module pc_stride_prefetcher_top_test;

    localparam int CLK_PERIOD     = 20;
    localparam int ENTRIES        = pcsp_pkg::TABLE_ENTRIES_DEFAULT;
    localparam int IDX_W          = $clog2(ENTRIES);
    localparam int STREAMS        = 8;
    localparam int SETTLE_CYCLES  = 24;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int NUM_PHASES     = 6;
    localparam int RANDOM_PER_PHASE = 125;

    typedef struct packed {
        logic [63:0] pc;
        logic [63:0] addr;
        logic        missed;
        logic        is_prefetch;
    } access_item_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wen = 1'b0;
    logic [3:0]   cfg_wdata = 4'd0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;    // access_pc [63:0], access_addr [127:64]
    logic [1:0]   s_axis_tuser = '0;    // missed [0], is_prefetch [1]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;         // prefetch_addr [63:0]

    pc_stride_prefetcher_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    access_item_t access_queue[$];
    access_item_t next_access;
    logic [63:0]  prefetch_expected[$];
    int           mismatch_count = 0;
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;

    // Predicted stride table and line size register.
    bit           tbl_valid  [ENTRIES];
    bit [63:0]    tbl_tag    [ENTRIES];
    bit [63:0]    tbl_last   [ENTRIES];
    bit [63:0]    tbl_stride [ENTRIES];
    bit [1:0]     tbl_conf   [ENTRIES];
    bit [3:0]     model_line_log2 = pcsp_pkg::LINE_LOG2_RESET;

    // Access streams used to train the table with random content.
    bit [63:0]    strm_pc     [STREAMS];
    bit [63:0]    strm_line   [STREAMS];
    bit [63:0]    strm_stride [STREAMS];

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit [63:0] pick_stride();
        int r;
        r = $urandom_range(9);
        if (r < 7) begin
            return $urandom_range(1) ? 64'($urandom_range(1, 8)) : -64'($urandom_range(1, 8));
        end else if (r == 7) begin
            return 64'd0;
        end else begin
            return rand64();
        end
    endfunction

    task automatic train_stride_table(input access_item_t a);
        bit [63:0] line;
        bit [63:0] stride;
        int        idx;
        if (!a.is_prefetch) begin
            line = a.addr >> model_line_log2;
            idx  = int'(a.pc % ENTRIES);
            if (tbl_valid[idx] && tbl_tag[idx] == a.pc) begin
                stride = line - tbl_last[idx];
                if (stride == tbl_stride[idx] && stride != 0) begin
                    if (tbl_conf[idx] != pcsp_pkg::CONF_MAX)
                        tbl_conf[idx] = tbl_conf[idx] + 2'd1;
                end else begin
                    tbl_stride[idx] = stride;
                    tbl_conf[idx]   = 2'd0;
                end
                if (tbl_conf[idx] >= pcsp_pkg::CONF_ISSUE && a.missed)
                    prefetch_expected.push_back((line + tbl_stride[idx]) << model_line_log2);
            end else begin
                tbl_valid[idx]  = 1'b1;
                tbl_tag[idx]    = a.pc;
                tbl_stride[idx] = 64'd0;
                tbl_conf[idx]   = 2'd0;
            end
            tbl_last[idx] = line;
        end
    endtask

    task automatic queue_access(input bit [63:0] pc, input bit [63:0] addr,
                                input bit missed, input bit is_prefetch);
        access_item_t a;
        a.pc          = pc;
        a.addr        = addr;
        a.missed      = missed;
        a.is_prefetch = is_prefetch;
        access_queue.push_back(a);
    endtask

    // Mostly strided streams with random offsets inside the line; the rest is
    // noise, including stray addresses on pcs that belong to a stream.
    task automatic queue_random_accesses(input int count);
        bit [63:0] mask;
        bit [63:0] nxt;
        bit [63:0] pc;
        int        s;
        mask = (64'd1 << model_line_log2) - 64'd1;
        for (int i = 0; i < count; i++) begin
            s = $urandom_range(STREAMS - 1);
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(63) == 0) begin
                    pc = rand64();
                    if ($urandom_range(1))
                        pc[IDX_W-1:0] = strm_pc[$urandom_range(STREAMS - 1)][IDX_W-1:0];
                    strm_pc[s] = pc;
                end
                if ($urandom_range(15) == 0)
                    strm_stride[s] = pick_stride();
                nxt = strm_line[s] + strm_stride[s];
                queue_access(strm_pc[s], (nxt << model_line_log2) | (rand64() & mask),
                             $urandom_range(99) < 80, $urandom_range(99) < 5);
                if (access_queue[$].is_prefetch == 1'b0)
                    strm_line[s] = nxt;
            end else begin
                pc = $urandom_range(1) ? strm_pc[s] : rand64();
                queue_access(pc, rand64(), 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic queue_directed_accesses();
        bit [63:0] p;
        p = 64'h0000_0000_0040_1234;
        queue_access(p, 64'h1000, 1'b1, 1'b0);            // install
        queue_access(p, 64'h1047, 1'b1, 1'b0);            // new stride, no result
        queue_access(p, 64'h1080, 1'b1, 1'b0);            // first prefetch
        queue_access(p, 64'h10C0, 1'b1, 1'b1);            // prefetch access, ignored
        queue_access(p, 64'h10C0, 1'b0, 1'b0);            // hit, not missed
        queue_access(p, 64'h1100, 1'b1, 1'b0);
        queue_access(p, 64'h113F, 1'b1, 1'b0);            // same line, zero stride resets confidence
        queue_access(p + ENTRIES, 64'h5000, 1'b1, 1'b0);  // same index, other tag
        queue_access(p, 64'h1180, 1'b1, 1'b0);            // reinstall after eviction
        repeat (3) queue_access(64'd0, 64'd0, 1'b1, 1'b0); // zero stride never trains
        queue_access('1, '1, 1'b1, 1'b0);
        queue_access('1, 64'hFFFF_FFFF_FFFF_FFBF, 1'b1, 1'b0);
        queue_access('1, 64'hFFFF_FFFF_FFFF_FF7F, 1'b1, 1'b0);
        queue_access(64'h8000_0000_0000_00FE, 64'h80, 1'b1, 1'b0);
        queue_access(64'h8000_0000_0000_00FE, 64'h40, 1'b1, 1'b0);
        queue_access(64'h8000_0000_0000_00FE, 64'h00, 1'b1, 1'b0); // wraps below zero
        queue_access(64'd1, 64'hFFFF_FFFF_FFFF_FF40, 1'b1, 1'b0);
        queue_access(64'd1, 64'hFFFF_FFFF_FFFF_FF80, 1'b1, 1'b0);
        queue_access(64'd1, 64'hFFFF_FFFF_FFFF_FFC0, 1'b1, 1'b0);  // wraps past the top
    endtask

    // Accesses that give no result may still be in the pipeline when the last
    // prefetch arrives, so a settling wait follows before the block counts as idle.
    task automatic wait_until_idle();
        while (access_queue.size() != 0 || s_axis_tvalid || prefetch_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_line_log2(input bit [3:0] value);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        model_line_log2 = value;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (access_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_access = access_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {next_access.addr, next_access.pc};
                s_axis_tuser  <= {next_access.is_prefetch, next_access.missed};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        access_item_t seen;
        logic [63:0]  want;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                seen.pc          = s_axis_tdata[63:0];
                seen.addr        = s_axis_tdata[127:64];
                seen.missed      = s_axis_tuser[0];
                seen.is_prefetch = s_axis_tuser[1];
                train_stride_table(seen);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (prefetch_expected.size() == 0) begin
                    $display("%0t: unexpected prefetch_addr: expected none, actual %h",
                             $time, m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = prefetch_expected.pop_front();
                    if (m_axis_tdata !== want) begin
                        $display("%0t: prefetch_addr mismatch: expected %h, actual %h",
                                 $time, want, m_axis_tdata);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        bit [3:0] phase_line_log2 [NUM_PHASES];
        int       idle_pattern_sender [4];
        int       idle_pattern_stall  [4];
        phase_line_log2     = '{4'd6, 4'd0, 4'd12, 4'd15, 4'd13, 4'd3};
        idle_pattern_sender = '{0, 57, 0, 10};
        idle_pattern_stall  = '{0, 0, 57, 10};
        for (int s = 0; s < STREAMS; s++) begin
            strm_pc[s]     = rand64();
            strm_line[s]   = rand64();
            strm_stride[s] = pick_stride();
        end
        strm_pc[1][IDX_W-1:0] = strm_pc[0][IDX_W-1:0];
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 0)
                queue_directed_accesses();
            else
                write_line_log2(phase_line_log2[ph]);
            sender_idle_pct    = idle_pattern_sender[ph % 4];
            receiver_stall_pct = idle_pattern_stall[ph % 4];
            queue_random_accesses(RANDOM_PER_PHASE);
            wait_until_idle();
        end
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
